@@ sv/skf_pkg.sv @@
// Shared constants, codes and control types of the scalar Kalman filter.
package skf_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 16;
  localparam int EST_W     = 48;
  localparam int VAR_W     = 32;
  localparam int DEN_W     = VAR_W + 1;
  localparam int REM_W     = VAR_W + 2;
  localparam int GAIN_W    = FRAC_BITS + 1;
  localparam int DIFF_W    = EST_W + 1;
  localparam int PACC_W    = DIFF_W + GAIN_W;
  localparam int VACC_W    = VAR_W + GAIN_W;

  // One gain bit per step: count GAIN_W steps down to zero
  localparam int CNT_W = $clog2(GAIN_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_W - 1);

  // Constants
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;
  localparam logic [VAR_W-1:0]  VAR_ONE  = VAR_W'(1) << FRAC_BITS;
  localparam longint unsigned   Q_RESET_L = (longint'(655) << FRAC_BITS) >> 16;
  localparam logic [VAR_W-1:0]  Q_RESET  = VAR_W'(Q_RESET_L);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = CFG_IDX_W'(1);

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic sum;
    logic setup;
    logic div_step;
    logic mul_setup;
    logic mul_step;
    logic commit;
    logic out_load;
  } skf_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_init;
  } skf_status_t;

endpackage

@@ sv/skf_ctrl.sv @@
// Sequencing state machine of the scalar Kalman filter.
module skf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  skf_pkg::skf_status_t status,
  output skf_pkg::skf_cmd_t    cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SUM    = 8'b0000_0010,
    ST_SETUP  = 8'b0000_0100,
    ST_DIV    = 8'b0000_1000,
    ST_MSETUP = 8'b0001_0000,
    ST_MUL    = 8'b0010_0000,
    ST_COMMIT = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } skf_state_t;

  skf_state_t                  state_r, state_nxt;
  logic [skf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        can_load;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign can_load  = !out_valid_r || out_ready;

  // Next state, step counter and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = status.is_init ? ST_EMIT : ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        cnt_nxt   = skf_pkg::CNT_LAST;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_MSETUP;
        end
      end
      ST_MSETUP: begin
        cmd.mul_setup = 1'b1;
        cnt_nxt       = skf_pkg::CNT_LAST;
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold until the output register is free
        if (can_load) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/skf_datapath.sv @@
// Datapath of the scalar Kalman filter: state, noise registers, divider, multipliers.
module skf_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_func,
  input  logic signed [skf_pkg::EST_W-1:0]       in_measurement,
  input  logic                                   cfg_write,
  input  logic [skf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [skf_pkg::VAR_W-1:0]              cfg_data,
  input  skf_pkg::skf_cmd_t                      cmd,
  output skf_pkg::skf_status_t                   status,
  output logic signed [skf_pkg::EST_W-1:0]       out_estimate
);

  // Configuration and filter state
  logic [skf_pkg::VAR_W-1:0]         q_r, r_r;
  logic signed [skf_pkg::EST_W-1:0]  est_r, est_nxt;
  logic [skf_pkg::VAR_W-1:0]         var_r, var_nxt;
  logic                              init_r;
  // Per-item working registers
  logic signed [skf_pkg::EST_W-1:0]  meas_r;
  logic [skf_pkg::VAR_W-1:0]         p_r, p_nxt;
  logic [skf_pkg::DEN_W-1:0]         den_r;
  logic signed [skf_pkg::DIFF_W-1:0] diff_r;
  logic [skf_pkg::REM_W-1:0]         rem_r, rem_nxt;
  logic [skf_pkg::GAIN_W-1:0]        gain_r, omk_r;
  logic signed [skf_pkg::PACC_W-1:0] pacc_r, pacc_nxt;
  logic [skf_pkg::VACC_W-1:0]        vacc_r, vacc_nxt;
  logic signed [skf_pkg::EST_W-1:0]  out_est_r;

  logic [skf_pkg::DEN_W-1:0]         sum_pq;
  logic                              div_ge;
  logic [skf_pkg::REM_W-1:0]         den_ext;
  logic [skf_pkg::REM_W-1:0]         rem_sub;

  assign status.is_init = in_func || !init_r;
  assign out_estimate   = out_est_r;

  // Saturating variance plus process noise
  assign sum_pq = {1'b0, var_r} + {1'b0, q_r};
  assign p_nxt  = sum_pq[skf_pkg::DEN_W-1] ? '1 : sum_pq[skf_pkg::VAR_W-1:0];

  // Restoring divide step: one gain bit, zero gain on a zero denominator
  assign den_ext = {1'b0, den_r};
  assign div_ge  = (rem_r >= den_ext) && (den_r != '0);
  assign rem_sub = div_ge ? (rem_r - den_ext) : rem_r;
  assign rem_nxt = rem_sub << 1;

  // Shift-add multiply steps, gain bits most significant first
  assign pacc_nxt = (pacc_r <<< 1)
                  + (gain_r[skf_pkg::GAIN_W-1] ? skf_pkg::PACC_W'(diff_r) : '0);
  assign vacc_nxt = (vacc_r << 1)
                  + (omk_r[skf_pkg::GAIN_W-1] ? skf_pkg::VACC_W'(p_r) : '0);

  // Floor of the products by 2^F
  assign est_nxt = est_r + $signed(pacc_r[skf_pkg::FRAC_BITS +: skf_pkg::EST_W]);
  assign var_nxt = vacc_r[skf_pkg::FRAC_BITS +: skf_pkg::VAR_W];

  // Control-relevant state: noise terms, estimate, variance, init flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r    <= skf_pkg::Q_RESET;
      r_r    <= skf_pkg::VAR_ONE;
      est_r  <= '0;
      var_r  <= skf_pkg::VAR_ONE;
      init_r <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          skf_pkg::CFG_PROCESS_NOISE:     q_r <= cfg_data;
          skf_pkg::CFG_MEASUREMENT_NOISE: r_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.accept && status.is_init) begin
        est_r  <= in_measurement;
        var_r  <= skf_pkg::VAR_ONE;
        init_r <= 1'b1;
      end else if (cmd.commit) begin
        est_r <= est_nxt;
        var_r <= var_nxt;
      end
    end
  end

  // Working registers of one update
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      meas_r <= in_measurement;
    end
    if (cmd.sum) begin
      p_r <= p_nxt;
    end
    if (cmd.setup) begin
      den_r  <= {1'b0, p_r} + {1'b0, r_r};
      diff_r <= skf_pkg::DIFF_W'(meas_r) - skf_pkg::DIFF_W'(est_r);
      rem_r  <= skf_pkg::REM_W'(p_r);
      gain_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= rem_nxt;
      gain_r <= {gain_r[skf_pkg::GAIN_W-2:0], div_ge};
    end
    if (cmd.mul_setup) begin
      omk_r  <= skf_pkg::GAIN_ONE - gain_r;
      pacc_r <= '0;
      vacc_r <= '0;
    end
    if (cmd.mul_step) begin
      pacc_r <= pacc_nxt;
      vacc_r <= vacc_nxt;
      gain_r <= gain_r << 1;
      omk_r  <= omk_r << 1;
    end
    if (cmd.out_load) begin
      out_est_r <= est_r;
    end
  end

endmodule

@@ sv/scalar_kalman_filter.sv @@
// Top level of the scalar Kalman filter: controller plus datapath.
//
//   Channel   Handshake              Payload
//   in_       in_valid / in_ready    in_func, in_measurement (signed Q32.16)
//   out_      out_valid / out_ready  out_estimate (signed Q32.16)
//   cfg_      cfg_valid / cfg_ready  cfg_index, cfg_data (Q16.16 noise terms)
//
// An update item passes through the sum, setup, restoring-divide, multiply-setup, shift-add
// multiply, commit and emit states from its acceptance to the next one; the restoring divider
// and the shift-add multipliers work one gain bit a cycle.
// An init item, or an update before the first init, goes from acceptance straight to emit.
// Synchronous active-low reset; config writes are always accepted, as cfg_ready is tied high.
// A stalled output holds the result register; the next item is taken once it loads.
module scalar_kalman_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic signed [skf_pkg::EST_W-1:0]    in_measurement,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [skf_pkg::EST_W-1:0]    out_estimate,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [skf_pkg::VAR_W-1:0]           cfg_data
);

  skf_pkg::skf_cmd_t    cmd;
  skf_pkg::skf_status_t status;

  assign cfg_ready = 1'b1;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  skf_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_func        (in_func),
    .in_measurement (in_measurement),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .status         (status),
    .out_estimate   (out_estimate)
  );

endmodule
